@@ rtl/tsmm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsmm_pkg
// Types, codes and constants shared by the scaled moving median block.
// ----------------------------------------------------------------------------
package tsmm_pkg;

    localparam int AXES      = 3;
    localparam int RAW_W     = 16;
    localparam int GAIN_W    = 32;
    localparam int DATA_W    = 48;
    localparam int CFG_IDX_W = 8;
    localparam int AXIS_W    = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0100_0000;  // 1.0 in Q8.24

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_X  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Y  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Z  = 8'd3;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REFILL = 1'b1;

    // one scaled vector, element AXIS_X/Y/Z
    typedef logic [AXES-1:0][DATA_W-1:0] t_vec;

    typedef struct packed {
        logic [AXES-1:0] less;
        logic [AXES-1:0] equal;
    } t_cmp_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_MUL,
        S_WRITE,
        S_CAND,
        S_LOAD,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

@@ rtl/tsmm_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsmm channel interfaces
// Sample input, configuration write and median result channels.
// ----------------------------------------------------------------------------
interface tsmm_in_if import tsmm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;

    modport source (output valid, kind, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, kind, raw_x, raw_y, raw_z, output ready);
endinterface

interface tsmm_cfg_if import tsmm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface tsmm_out_if import tsmm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] median_x;
    logic signed [DATA_W-1:0] median_y;
    logic signed [DATA_W-1:0] median_z;

    modport source (output valid, median_x, median_y, median_z, input ready);
    modport sink   (input valid, median_x, median_y, median_z, output ready);
endinterface
`default_nettype wire

@@ rtl/tsmm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsmm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tsmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/tsmm_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsmm_mul
// Shared gain multiplier: signed raw reading times unsigned Q8.24 gain.
// ----------------------------------------------------------------------------
module tsmm_mul import tsmm_pkg::*; (
    input  wire logic signed [RAW_W-1:0]  i_raw,
    input  wire logic        [GAIN_W-1:0] i_gain,
    output logic             [DATA_W-1:0] o_product
);
    logic signed [RAW_W+GAIN_W:0] full;

    // 16x33 signed product always fits in 48 bits
    assign full      = i_raw * $signed({1'b0, i_gain});
    assign o_product = full[DATA_W-1:0];
endmodule
`default_nettype wire

@@ rtl/tsmm_cmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsmm_cmp
// Per-axis signed compare of one window entry against the rank candidate.
// ----------------------------------------------------------------------------
module tsmm_cmp import tsmm_pkg::*; (
    input  wire t_vec       i_cand,
    input  wire t_vec       i_entry,
    output t_cmp_flags      o_flags
);
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_flags.less[a]  = $signed(i_entry[a]) < $signed(i_cand[a]);
            o_flags.equal[a] = i_entry[a] == i_cand[a];
        end
    end
endmodule
`default_nettype wire

@@ rtl/three_axis_scaled_moving_median.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_scaled_moving_median
// Scales a three-axis sample by a Q8.24 gain, stores it in a circular window
// and returns the per-axis element of rank WINDOW_SIZE/2.
// ----------------------------------------------------------------------------
// Sample item: three multiply steps (one per axis), one window write, then per rank
// candidate a candidate read, a load, a scan of every window entry and an evaluation.
// The next item is accepted only back in idle; a result still waiting holds
// the block in its last state. Refill item: initial vector to every entry, no result.
// Synchronous active-low reset: gain 1.0, initial vector zero, position zero,
// all window entries read as zero until written (per-entry valid bits).
module three_axis_scaled_moving_median import tsmm_pkg::*; #(
    parameter int WINDOW_SIZE = 5
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsmm_in_if.sink     i_in,
    tsmm_cfg_if.sink    i_cfg,
    tsmm_out_if.source  o_res
);
    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W:0]   RANK     = (CNT_W+1)'(WINDOW_SIZE / 2);

    t_state r_state, n_state;

    logic [GAIN_W-1:0]       r_gain;
    t_vec                    r_init;
    logic signed [RAW_W-1:0] r_raw [AXES];
    logic [AXIS_W-1:0]       r_axis;
    t_vec                    r_scaled;
    logic [IDX_W-1:0]        r_pos;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_j;
    logic [WINDOW_SIZE-1:0]  r_valid;
    logic                    r_rd_vld;
    t_vec                    r_cand;
    t_vec                    r_res;
    logic [CNT_W-1:0]        r_less  [AXES];
    logic [CNT_W-1:0]        r_equal [AXES];
    t_vec                    r_med;
    logic                    r_out_valid;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_vec              mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    t_vec              mem_rdata;
    t_vec              entry;
    t_cmp_flags        flags;
    logic [DATA_W-1:0] product;
    logic              out_load;

    tsmm_ram #(
        .WIDTH ($bits(t_vec)),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tsmm_mul u_mul (
        .i_raw     (r_raw[r_axis]),
        .i_gain    (r_gain),
        .o_product (product)
    );

    // entries never written since reset read as zero
    assign entry = r_rd_vld ? mem_rdata : '0;

    tsmm_cmp u_cmp (
        .i_cand  (r_cand),
        .i_entry (entry),
        .o_flags (flags)
    );

    assign i_in.ready     = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_res.valid    = r_out_valid;
    assign o_res.median_x = r_med[AXIS_X];
    assign o_res.median_y = r_med[AXIS_Y];
    assign o_res.median_z = r_med[AXIS_Z];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_scaled;
        mem_raddr = '0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.kind == KIND_REFILL) ? S_FILL : S_MUL;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_init;
                if (r_i == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                if (r_axis == AXIS_Z) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                mem_we  = 1'b1;
                n_state = S_CAND;
            end
            S_CAND: begin
                mem_raddr = r_i;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                mem_raddr = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (r_j == IDX_LAST) begin
                    n_state = S_EVAL;
                end else begin
                    mem_raddr = r_j + 1'b1;
                end
            end
            S_EVAL: begin
                n_state = (r_i == IDX_LAST) ? S_DONE : S_CAND;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration registers and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_init      <= '0;
            r_pos       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_axis      <= AXIS_X;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_SCALE_GAIN: r_gain         <= i_cfg.data[GAIN_W-1:0];
                    REG_INITIAL_X:  r_init[AXIS_X] <= i_cfg.data;
                    REG_INITIAL_Y:  r_init[AXIS_Y] <= i_cfg.data;
                    REG_INITIAL_Z:  r_init[AXIS_Z] <= i_cfg.data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_axis <= AXIS_X;
                    r_i    <= '0;
                end
                S_FILL: begin
                    r_valid[r_i] <= 1'b1;
                    r_i          <= r_i + 1'b1;
                    if (r_i == IDX_LAST) begin
                        r_pos <= '0;
                    end
                end
                S_MUL: begin
                    r_axis <= r_axis + 1'b1;
                end
                S_WRITE: begin
                    r_valid[r_pos] <= 1'b1;
                    r_pos          <= (r_pos == IDX_LAST) ? '0 : r_pos + 1'b1;
                end
                S_LOAD: begin
                    r_j <= '0;
                end
                S_SCAN: begin
                    r_j <= r_j + 1'b1;
                end
                S_EVAL: begin
                    r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[mem_raddr];

        if (r_state == S_IDLE && i_in.valid) begin
            r_raw[AXIS_X] <= i_in.raw_x;
            r_raw[AXIS_Y] <= i_in.raw_y;
            r_raw[AXIS_Z] <= i_in.raw_z;
        end

        if (r_state == S_MUL) begin
            r_scaled[r_axis] <= product;
        end

        if (r_state == S_LOAD) begin
            r_cand <= entry;
            for (int a = 0; a < AXES; a++) begin
                r_less[a]  <= '0;
                r_equal[a] <= '0;
            end
        end

        if (r_state == S_SCAN) begin
            for (int a = 0; a < AXES; a++) begin
                r_less[a]  <= r_less[a]  + CNT_W'(flags.less[a]);
                r_equal[a] <= r_equal[a] + CNT_W'(flags.equal[a]);
            end
        end

        // any candidate holding the median rank carries the median value
        if (r_state == S_EVAL) begin
            for (int a = 0; a < AXES; a++) begin
                if ({1'b0, r_less[a]} <= RANK &&
                    RANK < ({1'b0, r_less[a]} + {1'b0, r_equal[a]})) begin
                    r_res[a] <= r_cand[a];
                end
            end
        end

        if (out_load) begin
            r_med <= r_res;
        end
    end
endmodule
`default_nettype wire
